[rtl/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// Swept box collision package
// Shared types, codes and fixed-point helpers for the swept box collision unit.
// ----------------------------------------------------------------------------
package sbc_pkg;

  // Extended width for exact edge sums: 32-bit signed + 31-bit unsigned + 33-bit signed
  localparam int unsigned EdgeW = 36;

  localparam logic [15:0] DtReset = 16'd1092;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  localparam logic [2:0] SIDE_NONE  = 3'd0;
  localparam logic [2:0] SIDE_RIGHT = 3'd1;
  localparam logic [2:0] SIDE_LEFT  = 3'd2;
  localparam logic [2:0] SIDE_DOWN  = 3'd3;
  localparam logic [2:0] SIDE_UP    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_RESOLVE
  } state_e;

  // Multiplier schedule, one entry per cycle of the displacement phase
  typedef enum logic [1:0] {
    STEP_ACC_X,
    STEP_ACC_Y,
    STEP_DISP_X,
    STEP_DISP_Y
  } step_e;

  typedef struct packed {
    logic  load_obs;
    logic  take_test;
    logic  mul_en;
    step_e step;
    logic  check_en;
    logic  out_load;
  } cmd_t;

  function automatic logic signed [EdgeW-1:0] ext_s32(input logic [31:0] v);
    ext_s32 = {{(EdgeW-32){v[31]}}, v};
  endfunction

  function automatic logic signed [EdgeW-1:0] ext_u31(input logic [30:0] v);
    ext_u31 = {{(EdgeW-31){1'b0}}, v};
  endfunction

  function automatic logic signed [EdgeW-1:0] ext_s33(input logic [32:0] v);
    ext_s33 = {{(EdgeW-33){v[32]}}, v};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [EdgeW-1:0] v);
    logic signed [EdgeW-1:0] hi;
    logic signed [EdgeW-1:0] lo;
    hi = {{(EdgeW-31){1'b0}}, {31{1'b1}}};
    lo = {{(EdgeW-31){1'b1}}, {31{1'b0}}};
    if (v > hi) begin
      sat32 = 32'h7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[rtl/swept_box_collision_block_unit.sv]
// ----------------------------------------------------------------------------
// Swept box collision unit
// Swept AABB test of a mover against one stored obstacle, with snap response.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): action_i = 0 stores the obstacle
//   and produces no result. action_i = 1 tests the mover against the stored
//   obstacle and produces one result.
//   Output channel (out_valid_o / out_stall_i): one result per test item.
//   Config channel (cfg_valid_i / cfg_ready_o): writes delta_time (Q0.16);
//   ready is always high. Write it only while the unit is idle.
//   Sequence: a test item runs the displacement multiplies (steps ACC_X,
//   ACC_Y, DISP_X, DISP_Y on one 33x17 multiplier per body, shared over both
//   axes), then the side tests, then resolve; the next item is taken only
//   once the unit is back in idle, so tests do not overlap.
//   Reset: obstacle clears to all zero, delta_time to 1092, no result pending.
//   While the receiver stalls, the result holds; a finished test waits in the
//   resolve step and the unit still takes load items only after it drains.
// ----------------------------------------------------------------------------
module swept_box_collision_block_unit import sbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] box_x_i,
  input  logic [31:0] box_y_i,
  input  logic [30:0] box_w_i,
  input  logic [30:0] box_h_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] acc_x_i,
  input  logic [31:0] acc_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  hit_side_o,
  output logic        blocked_o,
  output logic [31:0] new_box_x_o,
  output logic [31:0] new_box_y_o,
  output logic [31:0] new_vel_x_o,
  output logic [31:0] new_vel_y_o
);

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  sbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  sbc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .box_x_i     (box_x_i),
    .box_y_i     (box_y_i),
    .box_w_i     (box_w_i),
    .box_h_i     (box_h_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .acc_x_i     (acc_x_i),
    .acc_y_i     (acc_y_i),
    .hit_side_o  (hit_side_o),
    .blocked_o   (blocked_o),
    .new_box_x_o (new_box_x_o),
    .new_box_y_o (new_box_y_o),
    .new_vel_x_o (new_vel_x_o),
    .new_vel_y_o (new_vel_y_o)
  );

  // A blocked result always names a side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blocked_o |-> hit_side_o != SIDE_NONE)
    else $error("blocked result without a hit side");

  // A horizontal snap zeroes the horizontal velocity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blocked_o && (hit_side_o == SIDE_RIGHT || hit_side_o == SIDE_LEFT)
    |-> new_vel_x_o == 32'd0)
    else $error("horizontal snap left velocity nonzero");

  // A load transfer leaves the input free in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ACT_LOAD |=> !in_stall_o)
    else $error("load item stalled the input");

  // A test transfer starts the multiply sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ACT_TEST |=> in_stall_o)
    else $error("test item did not start processing");

endmodule

[rtl/sbc_motion.sv]
// ----------------------------------------------------------------------------
// Swept box collision motion unit
// Frame displacement (v + a*dt)*dt of one body on a single shared multiplier.
// ----------------------------------------------------------------------------
module sbc_motion import sbc_pkg::*; (
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  input  logic        [15:0] dt_i,
  input  logic        [31:0] vel_x_i,
  input  logic        [31:0] vel_y_i,
  input  logic        [31:0] acc_x_i,
  input  logic        [31:0] acc_y_i,
  output logic signed [32:0] disp_x_o,
  output logic signed [32:0] disp_y_o
);

  logic        [31:0] ta_x_q, ta_y_q;
  logic signed [32:0] sum_x_q, sum_y_q;
  logic signed [32:0] disp_x_q, disp_y_q;
  logic signed [32:0] op;
  logic signed [16:0] dt_s;
  logic signed [49:0] prod;

  assign dt_s = {1'b0, dt_i};

  always_comb begin
    unique case (cmd_i.step)
      STEP_ACC_X:  op = {acc_x_i[31], acc_x_i};
      STEP_ACC_Y:  op = {acc_y_i[31], acc_y_i};
      STEP_DISP_X: op = sum_x_q;
      STEP_DISP_Y: op = sum_y_q;
      default:     op = sum_y_q;
    endcase
  end

  // Arithmetic shift of the product is the floor division by 2^16
  assign prod = op * dt_s;

  // Sums ride alongside the multiplies so no add sits in front of the multiplier
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.step)
        STEP_ACC_X: begin
          ta_x_q <= prod[47:16];
        end
        STEP_ACC_Y: begin
          ta_y_q  <= prod[47:16];
          sum_x_q <= {vel_x_i[31], vel_x_i} + {ta_x_q[31], ta_x_q};
        end
        STEP_DISP_X: begin
          disp_x_q <= prod[48:16];
          sum_y_q  <= {vel_y_i[31], vel_y_i} + {ta_y_q[31], ta_y_q};
        end
        STEP_DISP_Y: begin
          disp_y_q <= prod[48:16];
        end
        default: begin
          disp_y_q <= prod[48:16];
        end
      endcase
    end
  end

  assign disp_x_o = disp_x_q;
  assign disp_y_o = disp_y_q;

endmodule

[rtl/sbc_datapath.sv]
// ----------------------------------------------------------------------------
// Swept box collision datapath
// Obstacle and mover storage, displacement units, side tests and resolution.
// ----------------------------------------------------------------------------
module sbc_datapath import sbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [31:0] box_x_i,
  input  logic [31:0] box_y_i,
  input  logic [30:0] box_w_i,
  input  logic [30:0] box_h_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] acc_x_i,
  input  logic [31:0] acc_y_i,
  output logic [2:0]  hit_side_o,
  output logic        blocked_o,
  output logic [31:0] new_box_x_o,
  output logic [31:0] new_box_y_o,
  output logic [31:0] new_vel_x_o,
  output logic [31:0] new_vel_y_o
);

  logic [15:0] dt_q;

  logic [31:0] ob_x_q, ob_y_q, ob_vx_q, ob_vy_q, ob_ax_q, ob_ay_q;
  logic [30:0] ob_w_q, ob_h_q;
  logic [31:0] mv_x_q, mv_y_q, mv_vx_q, mv_vy_q, mv_ax_q, mv_ay_q;
  logic [30:0] mv_w_q, mv_h_q;

  logic signed [32:0] mdx, mdy, odx, ody;

  logic signed [EdgeW-1:0] mx, my, mw, mh, ox, oy, ow, oh;
  logic signed [EdgeW-1:0] m_right, m_bottom, o_right, o_bottom;
  logic ovl_x, ovl_y;
  logic [3:0] hit_d, hit_q;

  logic [2:0]  side_d;
  logic        blk_d;
  logic [31:0] nx_d, ny_d, nvx_d, nvy_d;
  logic [2:0]  side_q;
  logic        blk_q;
  logic [31:0] nx_q, ny_q, nvx_q, nvy_q;
  logic        vx_pos, vx_neg, vy_pos, vy_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= DtReset;
      ob_x_q  <= '0;
      ob_y_q  <= '0;
      ob_w_q  <= '0;
      ob_h_q  <= '0;
      ob_vx_q <= '0;
      ob_vy_q <= '0;
      ob_ax_q <= '0;
      ob_ay_q <= '0;
    end else begin
      if (cfg_we_i) begin
        dt_q <= cfg_wdata_i;
      end
      if (cmd_i.load_obs) begin
        ob_x_q  <= box_x_i;
        ob_y_q  <= box_y_i;
        ob_w_q  <= box_w_i;
        ob_h_q  <= box_h_i;
        ob_vx_q <= vel_x_i;
        ob_vy_q <= vel_y_i;
        ob_ax_q <= acc_x_i;
        ob_ay_q <= acc_y_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_test) begin
      mv_x_q  <= box_x_i;
      mv_y_q  <= box_y_i;
      mv_w_q  <= box_w_i;
      mv_h_q  <= box_h_i;
      mv_vx_q <= vel_x_i;
      mv_vy_q <= vel_y_i;
      mv_ax_q <= acc_x_i;
      mv_ay_q <= acc_y_i;
    end
  end

  sbc_motion u_mover_motion (
    .clk_i    (clk_i),
    .cmd_i    (cmd_i),
    .dt_i     (dt_q),
    .vel_x_i  (mv_vx_q),
    .vel_y_i  (mv_vy_q),
    .acc_x_i  (mv_ax_q),
    .acc_y_i  (mv_ay_q),
    .disp_x_o (mdx),
    .disp_y_o (mdy)
  );

  sbc_motion u_obstacle_motion (
    .clk_i    (clk_i),
    .cmd_i    (cmd_i),
    .dt_i     (dt_q),
    .vel_x_i  (ob_vx_q),
    .vel_y_i  (ob_vy_q),
    .acc_x_i  (ob_ax_q),
    .acc_y_i  (ob_ay_q),
    .disp_x_o (odx),
    .disp_y_o (ody)
  );

  assign mx = ext_s32(mv_x_q);
  assign my = ext_s32(mv_y_q);
  assign mw = ext_u31(mv_w_q);
  assign mh = ext_u31(mv_h_q);
  assign ox = ext_s32(ob_x_q);
  assign oy = ext_s32(ob_y_q);
  assign ow = ext_u31(ob_w_q);
  assign oh = ext_u31(ob_h_q);

  assign m_right  = mx + mw;
  assign m_bottom = my + mh;
  assign o_right  = ox + ow;
  assign o_bottom = oy + oh;

  assign ovl_y = (m_bottom > oy) && (my < o_bottom);
  assign ovl_x = (m_right > ox) && (mx < o_right);

  // Bit 0 right, 1 left, 2 down, 3 up
  always_comb begin
    hit_d[0] = (m_right + ext_s33(mdx) >= ox + ext_s33(odx)) && (m_right <= ox) && ovl_y;
    hit_d[1] = (mx + ext_s33(mdx) <= o_right + ext_s33(odx)) && (mx >= o_right) && ovl_y;
    hit_d[2] = (m_bottom + ext_s33(mdy) >= oy + ext_s33(ody)) && (m_bottom <= oy) && ovl_x;
    hit_d[3] = (my + ext_s33(mdy) <= o_bottom + ext_s33(ody)) && (my >= o_bottom) && ovl_x;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check_en) begin
      hit_q <= hit_d;
    end
  end

  assign vx_pos = !mv_vx_q[31] && (mv_vx_q != '0);
  assign vx_neg = mv_vx_q[31];
  assign vy_pos = !mv_vy_q[31] && (mv_vy_q != '0);
  assign vy_neg = mv_vy_q[31];

  // First matching side wins; snap only when moving toward it
  always_comb begin
    side_d = SIDE_NONE;
    blk_d  = 1'b0;
    nx_d   = mv_x_q;
    ny_d   = mv_y_q;
    nvx_d  = mv_vx_q;
    nvy_d  = mv_vy_q;
    if (hit_q[0]) begin
      side_d = SIDE_RIGHT;
      if (vx_pos) begin
        nx_d  = sat32(ox - mw);
        nvx_d = '0;
        blk_d = 1'b1;
      end
    end else if (hit_q[1]) begin
      side_d = SIDE_LEFT;
      if (vx_neg) begin
        nx_d  = sat32(o_right);
        nvx_d = '0;
        blk_d = 1'b1;
      end
    end else if (hit_q[2]) begin
      side_d = SIDE_DOWN;
      if (vy_pos) begin
        ny_d  = sat32(oy - mh);
        nvy_d = '0;
        blk_d = 1'b1;
      end
    end else if (hit_q[3]) begin
      side_d = SIDE_UP;
      if (vy_neg) begin
        ny_d  = sat32(o_bottom);
        nvy_d = '0;
        blk_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      side_q <= side_d;
      blk_q  <= blk_d;
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      nvx_q  <= nvx_d;
      nvy_q  <= nvy_d;
    end
  end

  assign hit_side_o  = side_q;
  assign blocked_o   = blk_q;
  assign new_box_x_o = nx_q;
  assign new_box_y_o = ny_q;
  assign new_vel_x_o = nvx_q;
  assign new_vel_y_o = nvy_q;

endmodule

[rtl/sbc_ctrl.sv]
// ----------------------------------------------------------------------------
// Swept box collision controller
// Sequences loads, the displacement multiplies, the side tests and the result.
// ----------------------------------------------------------------------------
module sbc_ctrl import sbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic action_i,
  input  logic out_stall_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_busy;

  assign out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_ACC_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = STEP_ACC_X;
        if (in_valid_i && (action_i == ACT_TEST)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        unique case (step_q)
          STEP_ACC_X:  step_d = STEP_ACC_Y;
          STEP_ACC_Y:  step_d = STEP_DISP_X;
          STEP_DISP_X: step_d = STEP_DISP_Y;
          STEP_DISP_Y: begin
            step_d  = STEP_ACC_X;
            state_d = ST_CHECK;
          end
          default:     step_d = STEP_ACC_X;
        endcase
      end
      ST_CHECK: begin
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        // Hold until the output register is free
        if (!out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    accept         = in_valid_i && !in_stall_o;
    cmd_o.load_obs  = accept && (action_i == ACT_LOAD);
    cmd_o.take_test = accept && (action_i == ACT_TEST);
    cmd_o.mul_en    = (state_q == ST_MUL);
    cmd_o.step      = step_q;
    cmd_o.check_en  = (state_q == ST_CHECK);
    cmd_o.out_load  = (state_q == ST_RESOLVE) && !out_busy;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
